>>> src/bb_pkg.sv
// Shared constants and types of the 3x3 box blur stream.
`default_nettype none

package bb_pkg;

  // Frame limits used as defaults for the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Register reset value for both frame dimensions
  localparam int unsigned RESET_DIM = 1024;

  // Pixel and configuration port widths
  localparam int unsigned PIX_W        = 24;
  localparam int unsigned CFG_DW       = 13;
  localparam int unsigned CFG_IW       = 1;
  localparam int unsigned CFG_WIDTH_W  = 11;
  localparam int unsigned CFG_HEIGHT_W = 13;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 1'b1;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Per-item control decided in the front
  typedef struct packed {
    logic wr;         // pixel goes into the row stores
    logic emit;       // item produces a result
    logic has_above;  // output row has a row above it
    logic has_below;  // output row has a row below it
    logic has_left;   // output column has a column to its left
    logic has_right;  // output column has a column to its right
    logic fend;       // result is the last pixel of the frame
  } bb_ctrl_t;

endpackage

`default_nettype wire

>>> src/box_blur_3x3_stream.sv
// A result passes the store read, column sum, rounded sum and output registers once
//   the item completing its neighborhood (one row and one pixel later) is taken.
// Throughput: one item per cycle; the back end advances whenever its output register
//   is empty or taken, and a 4-entry queue decouples it from the input side.
// Reset: clears positions, window, queue and pipeline; width and height return to 1024.
//   The row stores are not cleared; an entry is always written before it counts.
`default_nettype none

module box_blur_3x3_stream #(
  parameter int unsigned MAX_WIDTH  = bb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bb_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  wire logic [bb_pkg::CFG_DW-1:0]  cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       mode_i,
  input  wire logic [7:0]                 in_red_i,
  input  wire logic [7:0]                 in_green_i,
  input  wire logic [7:0]                 in_blue_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_blue_o,
  output logic                            frame_end_o
);
  import bb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned CTW = $bits(bb_ctrl_t);
  localparam int unsigned DW = CTW + CW + PIX_W;

  logic             f_push, q_full, q_valid, q_pop;
  bb_ctrl_t         f_ctrl, b_ctrl;
  logic [PIX_W-1:0] f_pix, b_pix;
  logic [CW-1:0]    f_col, b_col;
  logic [DW-1:0]    q_wdata, q_rdata;

  bb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .q_full_i   (q_full),
    .q_push_o   (f_push),
    .q_ctrl_o   (f_ctrl),
    .q_pix_o    (f_pix),
    .q_col_o    (f_col)
  );

  // Pack and unpack queue entries
  assign q_wdata = {f_ctrl, f_col, f_pix};
  assign b_ctrl  = q_rdata[DW-1 -: CTW];
  assign b_col   = q_rdata[PIX_W +: CW];
  assign b_pix   = q_rdata[PIX_W-1:0];

  bb_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  bb_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_ctrl_i    (b_ctrl),
    .q_pix_i     (b_pix),
    .q_col_i     (b_col),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire

>>> src/bb_front.sv
// Front end: configuration registers, input transfer, position tracking and classification.
`default_nettype none

module bb_front #(
  parameter int unsigned MAX_WIDTH  = bb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bb_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bb_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  wire logic [bb_pkg::CFG_DW-1:0]  cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       mode_i,
  input  wire logic [7:0]                 in_red_i,
  input  wire logic [7:0]                 in_green_i,
  input  wire logic [7:0]                 in_blue_i,
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output bb_pkg::bb_ctrl_t                q_ctrl_o,
  output logic [bb_pkg::PIX_W-1:0]        q_pix_o,
  output logic [CW-1:0]                   q_col_o
);
  import bb_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned W_RST = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
  localparam int unsigned H_RST = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [CFG_WIDTH_W-1:0]  cfg_w;
  logic [CFG_HEIGHT_W-1:0] cfg_h;
  logic                    accept, done, ignore, col_wrap, step_wrap;
  logic [CW-1:0]           c0, ocol, w_m1;
  logic [RW-1:0]           r0, orow, h_m1;
  logic [WW-1:0]           c1;
  logic                    emit, last_row, last_col, fend;

  // Clamp register writes into the supported frame range
  assign cfg_w = cfg_data_i[CFG_WIDTH_W-1:0];
  assign cfg_h = cfg_data_i[CFG_HEIGHT_W-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i && cfg_idx_i == REG_WIDTH) begin
      if (cfg_w == '0) begin
        width_d = WW'(1);
      end else if (32'(cfg_w) > MAX_WIDTH) begin
        width_d = WW'(MAX_WIDTH);
      end else begin
        width_d = WW'(cfg_w);
      end
    end
    if (cfg_we_i && cfg_idx_i == REG_HEIGHT) begin
      if (cfg_h == '0) begin
        height_d = HW'(1);
      end else if (32'(cfg_h) > MAX_HEIGHT) begin
        height_d = HW'(MAX_HEIGHT);
      end else begin
        height_d = HW'(cfg_h);
      end
    end
  end

  // Wrap a column left beyond a narrowed width
  assign col_wrap = WW'(col_q) >= width_q;
  assign c0       = col_wrap ? '0 : col_q;
  assign r0       = col_wrap ? row_q + RW'(1) : row_q;
  assign done     = r0 >= RW'(height_q);
  assign ignore   = mode_i && !done;

  // Advance the input position
  assign c1        = WW'(c0) + WW'(1);
  assign step_wrap = c1 >= width_q;

  // Locate the output pixel that this item completes
  assign w_m1 = CW'(width_q - WW'(1));
  assign h_m1 = RW'(height_q - HW'(1));
  assign emit = (r0 >= RW'(1) && c0 != '0) || r0 >= RW'(2);
  assign orow = (c0 != '0) ? r0 - RW'(1) : r0 - RW'(2);
  assign ocol = (c0 != '0) ? c0 - CW'(1) : w_m1;
  assign last_row = orow >= h_m1;
  assign last_col = ocol >= w_m1;
  assign fend     = emit && last_row && last_col;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && !ignore;

  // Classify the item for the back end
  always_comb begin
    q_ctrl_o.wr        = !done;
    q_ctrl_o.emit      = emit;
    q_ctrl_o.has_above = orow != '0;
    q_ctrl_o.has_below = orow < h_m1;
    q_ctrl_o.has_left  = ocol != '0;
    q_ctrl_o.has_right = ocol < w_m1;
    q_ctrl_o.fend      = fend;
    q_pix_o            = done ? '0 : {in_red_i, in_green_i, in_blue_i};
    q_col_o            = c0;
  end

  // Next position: hold the wrap on an ignored drain, restart after frame end
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (ignore) begin
        col_d = c0;
        row_d = r0;
      end else if (fend) begin
        col_d = '0;
        row_d = '0;
      end else if (step_wrap) begin
        col_d = '0;
        row_d = r0 + RW'(1);
      end else begin
        col_d = CW'(c1);
        row_d = r0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(W_RST);
      height_q <= HW'(H_RST);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

`default_nettype wire

>>> src/bb_queue.sv
// Short FIFO queue between the front end and the back end.
`default_nettype none

module bb_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = bb_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output logic [DW-1:0]      data_o
);
  import bb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/bb_back.sv
// Back end: row stores, 3x3 window, neighborhood sums and rounded averages.
`default_nettype none

module bb_back #(
  parameter int unsigned MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  output logic                           q_pop_o,
  input  wire bb_pkg::bb_ctrl_t          q_ctrl_i,
  input  wire logic [bb_pkg::PIX_W-1:0]  q_pix_i,
  input  wire logic [CW-1:0]             q_col_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [7:0]                     out_red_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_blue_o,
  output logic                           frame_end_o
);
  import bb_pkg::*;

  typedef enum logic [2:0] {CNT_1, CNT_2, CNT_3, CNT_4, CNT_6, CNT_9} count_e;

  // Reciprocal of the divisor in 16 fraction bits; divisor six halves the operand first
  function automatic logic [16:0] recip(count_e c);
    logic [16:0] k;
    case (c)
      CNT_1:   k = 17'd65536;
      CNT_2:   k = 17'd32768;
      CNT_3:   k = 17'd21846;
      CNT_4:   k = 17'd16384;
      CNT_6:   k = 17'd21846;
      CNT_9:   k = 17'd7282;
      default: k = 17'd65536;
    endcase
    return k;
  endfunction

  logic adv, pop;

  // Row stores: a holds the previous row, b the row before it
  logic [PIX_W-1:0] a_mem [MAX_WIDTH];
  logic [PIX_W-1:0] b_mem [MAX_WIDTH];

  // Stage 1: store read data
  logic             v1_q, pend_q, fwd_q;
  bb_ctrl_t         ctrl1_q;
  logic [CW-1:0]    col1_q;
  logic [PIX_W-1:0] pix1_q, a_rd_q, b_rd_q, fwd_dat_q;

  // Window and stage 2: column sums
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] win_d [3][3];
  logic [PIX_W-1:0] newcol [3];
  logic [2:0]       rmask;
  logic [9:0]       cs_d [3][3];
  logic [9:0]       cs_q [3][3];
  logic             v2_q;
  bb_ctrl_t         ctrl2_q;

  // Stage 3: rounded sum and divisor
  logic [11:0] tot [3];
  logic [11:0] y_d [3];
  logic [11:0] y_q [3];
  logic [1:0]  nr, nc;
  count_e      cnt_d, cnt3_q;
  logic [2:0]  half;
  logic        v3_q, fend3_q;

  // Stage 4: output register
  logic [11:0] m [3];
  logic [28:0] prod [3];
  logic [16:0] k;
  logic [7:0]  res_q [3];
  logic        out_valid_q, fend_q;

  assign adv     = !out_valid_q || out_ready_i;
  assign pop     = adv && q_valid_i;
  assign q_pop_o = pop;

  // Read both stores, write the new pixel now and the shifted row in the cycle after
  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_rd_q    <= a_mem[q_col_i];
      b_rd_q    <= b_mem[q_col_i];
      fwd_dat_q <= a_rd_q;
      col1_q    <= q_col_i;
      pix1_q    <= q_pix_i;
      ctrl1_q   <= q_ctrl_i;
      if (q_ctrl_i.wr) begin
        a_mem[q_col_i] <= q_pix_i;
      end
    end
    if (pend_q) begin
      b_mem[col1_q] <= a_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      pend_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      pend_q <= pop && q_ctrl_i.wr;
      if (adv) begin
        v1_q <= pop;
      end
      if (pop) begin
        fwd_q <= pend_q && (col1_q == q_col_i);
      end
    end
  end

  // Shift the window and sum each column over the rows inside the frame
  always_comb begin
    newcol[0] = fwd_q ? fwd_dat_q : b_rd_q;
    newcol[1] = a_rd_q;
    newcol[2] = pix1_q;
    rmask     = {ctrl1_q.has_below, 1'b1, ctrl1_q.has_above};
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
      win_d[i][2] = newcol[i];
    end
    for (int j = 0; j < 3; j++) begin
      for (int ch = 0; ch < 3; ch++) begin
        cs_d[j][ch] = '0;
        for (int i = 0; i < 3; i++) begin
          if (rmask[i]) begin
            cs_d[j][ch] = cs_d[j][ch] + 10'(win_d[i][j][8*(2-ch) +: 8]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (adv && v1_q) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= ctrl1_q.fend ? '0 : win_d[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cs_q    <= cs_d;
      ctrl2_q <= ctrl1_q;
    end
  end

  // Total over the columns inside the frame and pick the divisor
  always_comb begin
    nr = 2'd1 + 2'(ctrl2_q.has_above) + 2'(ctrl2_q.has_below);
    nc = 2'd1 + 2'(ctrl2_q.has_left) + 2'(ctrl2_q.has_right);
    case ({nr, nc})
      {2'd1, 2'd1}: cnt_d = CNT_1;
      {2'd1, 2'd2}: cnt_d = CNT_2;
      {2'd2, 2'd1}: cnt_d = CNT_2;
      {2'd1, 2'd3}: cnt_d = CNT_3;
      {2'd3, 2'd1}: cnt_d = CNT_3;
      {2'd2, 2'd2}: cnt_d = CNT_4;
      {2'd2, 2'd3}: cnt_d = CNT_6;
      {2'd3, 2'd2}: cnt_d = CNT_6;
      {2'd3, 2'd3}: cnt_d = CNT_9;
      default:      cnt_d = CNT_1;
    endcase
    // Half the divisor, rounded down, makes the average round half up
    case (cnt_d)
      CNT_1:   half = 3'd0;
      CNT_2:   half = 3'd1;
      CNT_3:   half = 3'd1;
      CNT_4:   half = 3'd2;
      CNT_6:   half = 3'd3;
      CNT_9:   half = 3'd4;
      default: half = 3'd0;
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = (ctrl2_q.has_left ? 12'(cs_q[0][ch]) : 12'd0) + 12'(cs_q[1][ch]) +
                (ctrl2_q.has_right ? 12'(cs_q[2][ch]) : 12'd0);
      y_d[ch] = tot[ch] + 12'(half);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q    <= y_d;
      cnt3_q <= cnt_d;
    end
  end

  // Divide by multiplying with the reciprocal
  always_comb begin
    k = recip(cnt3_q);
    for (int ch = 0; ch < 3; ch++) begin
      m[ch]    = (cnt3_q == CNT_6) ? {1'b0, y_q[ch][11:1]} : y_q[ch];
      prod[ch] = 29'(m[ch]) * 29'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        res_q[ch] <= prod[ch][23:16];
      end
    end
  end

  // Advance the valid bits of stages 2 to 4
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      fend3_q     <= 1'b0;
      out_valid_q <= 1'b0;
      fend_q      <= 1'b0;
    end else if (adv) begin
      v2_q        <= v1_q && ctrl1_q.emit;
      v3_q        <= v2_q;
      fend3_q     <= ctrl2_q.fend;
      out_valid_q <= v3_q;
      fend_q      <= fend3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o  = res_q[2];
  assign frame_end_o = fend_q;

endmodule

`default_nettype wire

>>> test/blur_checker.sv
// Checker for the 3x3 box blur stream: tracks registers, predicts results and compares them.
module blur_checker
  import bb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IW-1:0]   cfg_idx_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                mode_i,
  input  logic [7:0]          in_red_i,
  input  logic [7:0]          in_green_i,
  input  logic [7:0]          in_blue_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [7:0]          out_red_i,
  input  logic [7:0]          out_green_i,
  input  logic [7:0]          out_blue_i,
  input  logic                frame_end_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         frames_o,
  output logic                input_done_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } blur_px_t;

  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]        line_prev  [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]        line_above [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]        win [3][3];
  int unsigned             col_pos;
  int unsigned             row_pos;
  int unsigned             result_idx;
  blur_px_t                blur_q [$];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] round_avg(int unsigned sum, int unsigned cnt);
    return 8'((2 * sum + cnt) / (2 * cnt));
  endfunction

  task automatic note_fail(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  // Advance the window by one accepted item and queue the blurred pixel it completes
  task automatic blur_pixel(input logic drain, input logic [PIX_W-1:0] px_in);
    int unsigned w, h, r, c, orow, ocol, cnt;
    int unsigned sum [3];
    logic done;
    logic [PIX_W-1:0] above, prev, px;
    logic ok_row [3];
    logic ok_col [3];
    blur_px_t res;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    // a column left beyond a shrunk width wraps first
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    done = row_pos >= h;
    if (drain && !done) return;

    r = row_pos;
    c = col_pos;
    prev = line_prev[c];
    above = line_above[c];
    px = '0;
    if (!done) begin
      px = px_in;
      line_above[c] = prev;
      line_prev[c] = px;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = above;
    win[1][2] = prev;
    win[2][2] = px;

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end

    // no result until one row plus one pixel has arrived
    if (!((r >= 1 && c >= 1) || r >= 2)) return;
    if (c >= 1) begin
      orow = r - 1;
      ocol = c - 1;
    end else begin
      orow = r - 2;
      ocol = w - 1;
    end

    ok_row[0] = orow >= 1;
    ok_row[1] = 1'b1;
    ok_row[2] = orow + 1 < h;
    ok_col[0] = ocol >= 1;
    ok_col[1] = 1'b1;
    ok_col[2] = ocol + 1 < w;
    sum = '{0, 0, 0};
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (ok_row[i] && ok_col[j]) begin
          for (int k = 0; k < 3; k++) sum[k] += win[i][j][(23 - 8 * k) -: 8];
          cnt++;
        end
      end
    end
    res.red = round_avg(sum[0], cnt);
    res.green = round_avg(sum[1], cnt);
    res.blue = round_avg(sum[2], cnt);
    res.fend = 1'b0;

    // last pixel of the frame: restart positions and window
    if (orow + 1 >= h && ocol + 1 >= w) begin
      res.fend = 1'b1;
      col_pos = 0;
      row_pos = 0;
      win = '{default: '0};
      frames_o++;
    end
    blur_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    blur_px_t got, want;
    if (!rst_ni) begin
      width_reg = CFG_WIDTH_W'(RESET_DIM);
      height_reg = CFG_HEIGHT_W'(RESET_DIM);
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        line_prev[i] = '0;
        line_above[i] = '0;
      end
      win = '{default: '0};
      col_pos = 0;
      row_pos = 0;
      result_idx = 0;
      blur_q.delete();
      fail_count_o = 0;
      frames_o = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WIDTH) width_reg = cfg_data_i[CFG_WIDTH_W-1:0];
        else if (cfg_idx_i == REG_HEIGHT) height_reg = cfg_data_i[CFG_HEIGHT_W-1:0];
      end
      // compare each output transfer with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = {out_red_i, out_green_i, out_blue_i, frame_end_i};
        if (blur_q.size() == 0) begin
          note_fail($sformatf("result %0d: got %02h %02h %02h end %0b with none expected",
                              result_idx, got.red, got.green, got.blue, got.fend));
        end else begin
          want = blur_q.pop_front();
          if (got !== want)
            note_fail($sformatf({"result %0d: expected %02h %02h %02h end %0b, ",
                                 "got %02h %02h %02h end %0b"}, result_idx,
                                want.red, want.green, want.blue, want.fend,
                                got.red, got.green, got.blue, got.fend));
        end
        result_idx++;
      end
      // predict from each input transfer
      if (in_valid_i && in_ready_i) blur_pixel(mode_i, {in_red_i, in_green_i, in_blue_i});
    end
    pending_o = blur_q.size();
    input_done_o = ((col_pos >= clamp_dim(width_reg, MAX_WIDTH_DEF)) ? row_pos + 1 : row_pos)
                   >= clamp_dim(height_reg, MAX_HEIGHT_DEF);
  end

endmodule

>>> test/tb_box_blur_3x3_stream.sv
// Top of the box blur testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_box_blur_3x3_stream;
  timeunit 1ns;
  timeprecision 1ps;
  import bb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 1750;
  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam logic        MODE_PIXEL    = 1'b0;
  localparam logic        MODE_DRAIN    = 1'b1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              mode_i;
  logic [7:0]        in_red_i;
  logic [7:0]        in_green_i;
  logic [7:0]        in_blue_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        out_red_o;
  logic [7:0]        out_green_o;
  logic [7:0]        out_blue_o;
  logic              frame_end_o;

  int unsigned       fail_cnt;
  int unsigned       pending_cnt;
  int unsigned       frame_cnt;
  logic              input_done;
  int unsigned       cycle_cnt = 0;
  logic              tx_calm = 1'b0;
  logic              rx_calm = 1'b0;
  int unsigned       items_sent;
  int unsigned       cur_w;
  int unsigned       cur_h;

  box_blur_3x3_stream u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .frame_end_o (frame_end_o)
  );

  blur_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_i    (out_red_o),
    .out_green_i  (out_green_o),
    .out_blue_i   (out_blue_o),
    .frame_end_i  (frame_end_o),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt),
    .frames_o     (frame_cnt),
    .input_done_o (input_done)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Abort a hung run
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Random pixel, each channel often pinned to an extreme
  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] px;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 4) == 0) px[8 * k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else px[8 * k +: 8] = 8'($urandom_range(0, 255));
    end
    return px;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic mode, input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = mode;
    {in_red_i, in_green_i, in_blue_i} = px;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold the sender until every predicted result has left, then let the pipeline empty
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_DW'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
    settle();
    write_reg(REG_WIDTH, w_raw);
    write_reg(REG_HEIGHT, h_raw);
    cur_w = (w_raw == 0) ? 1 : ((w_raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_raw);
    cur_h = (h_raw == 0) ? 1 : ((h_raw > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h_raw);
  endtask

  // One frame: pixels until input completes, then drain until the frame closes.
  // Optionally narrow the width and retarget the height after change_at pixels.
  task automatic run_frame(input int unsigned change_at, input int unsigned new_w,
                           input int unsigned new_h);
    int unsigned start, n;
    start = frame_cnt;
    n = 0;
    while (!input_done) begin
      if ($urandom_range(0, 99) < 4) begin
        // early drain tick, dropped by the block
        send_item(MODE_DRAIN, pick_pixel());
      end else begin
        send_item(MODE_PIXEL, pick_pixel());
        n++;
        items_sent++;
        if (n == change_at) set_frame(new_w, new_h);
      end
    end
    // a pixel after the input is complete counts as a drain tick
    while (frame_cnt == start) begin
      send_item(($urandom_range(0, 4) == 0) ? MODE_PIXEL : MODE_DRAIN, pick_pixel());
      items_sent++;
    end
    // drain tick after the frame closed belongs to the next frame and is dropped
    if ($urandom_range(0, 9) == 0) send_item(MODE_DRAIN, pick_pixel());
  endtask

  // Receiver: stall a random number of cycles before each result
  initial begin : rx_side
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] corner_px [6];
    int unsigned w_raw, h_raw, change_at, start;
    corner_px = '{24'h000000, 24'hFFFFFF, 24'hFF0080, 24'h00FF7F, 24'h808080, 24'h01FE55};
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_PIXEL;
    in_red_i = '0;
    in_green_i = '0;
    in_blue_i = '0;
    items_sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // 3x2 frame with extreme pixels, a drain before completion, a late pixel and a stray drain
    set_frame(3, 2);
    start = frame_cnt;
    send_item(MODE_DRAIN, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) begin
      send_item(MODE_PIXEL, corner_px[i]);
      if (i == 2) send_item(MODE_DRAIN, 24'h000000);
    end
    send_item(MODE_PIXEL, 24'hFFFFFF);
    while (frame_cnt == start) send_item(MODE_DRAIN, 24'h000000);
    send_item(MODE_DRAIN, 24'hFFFFFF);

    // zero registers saturate to a single pixel
    set_frame(0, 0);
    run_frame(0, 0, 0);

    // oversized height, then narrow and cut the frame while it runs
    set_frame(4, 8191);
    run_frame(8, 3, 3);

    // random frames, mostly small
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       w_raw = 0;
        1, 2:    w_raw = $urandom_range(13, 64);
        default: w_raw = $urandom_range(1, 12);
      endcase
      if (w_raw > 12) h_raw = $urandom_range(1, 3);
      else if ($urandom_range(0, 19) == 0) h_raw = 0;
      else if ($urandom_range(0, 19) == 0) h_raw = $urandom_range(9, 24);
      else h_raw = $urandom_range(1, 8);
      set_frame(w_raw, h_raw);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      change_at = 0;
      if ($urandom_range(0, 99) < 15) change_at = $urandom_range(1, cur_w * cur_h);
      run_frame(change_at, $urandom_range(0, cur_w), $urandom_range(0, 10));
    end

    settle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
